@@ hw/rtl/onewire_temp_scratchpad_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 1-Wire scratchpad decoder.
// Both macros sample on the rising edge of clk and are disabled while
// arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_TEMP_SCRATCHPAD_DECODER_ASSERT_SVH
`define ONEWIRE_TEMP_SCRATCHPAD_DECODER_ASSERT_SVH

// A condition that must hold at every clock edge.
`define OWTS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define OWTS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/owts_pkg.sv @@
// ----------------------------------------------------------------------------
// owts_pkg
// Types and constants shared by the 1-Wire scratchpad decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package owts_pkg;

	localparam int unsigned SCRATCH_BYTES = 9;
	localparam int unsigned BYTE_IDX_W    = 4;
	localparam int unsigned CFG_IDX_W     = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FAMILY_CODE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERRORS  = 4'd1;

	localparam logic [7:0] FAMILY_RESET     = 8'd40;
	localparam logic [7:0] MAX_ERRORS_RESET = 8'd3;

	// Input actions.
	localparam logic [1:0] ACT_BYTE    = 2'd0;
	localparam logic [1:0] ACT_BUS     = 2'd1;
	localparam logic [1:0] ACT_NO_ADDR = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_FRESH   = 2'd0;
	localparam logic [1:0] ST_HELD    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	// Error causes.
	localparam logic [2:0] CAUSE_NONE    = 3'd0;
	localparam logic [2:0] CAUSE_NO_ADDR = 3'd1;
	localparam logic [2:0] CAUSE_BUS     = 3'd2;
	localparam logic [2:0] CAUSE_CRC     = 3'd3;
	localparam logic [2:0] CAUSE_RANGE   = 3'd4;

	localparam logic [7:0]  CRC_POLY        = 8'h8C;
	localparam logic [7:0]  NINE_BIT_FAMILY = 8'h10;
	localparam logic [7:0]  COUNT_PER_C_16  = 8'h10;
	localparam logic [15:0] FRAC_CLEAR_MASK = 16'hFFF0;
	localparam logic [15:0] HALF_STEP_BIAS  = 16'd12;
	localparam logic [7:0]  RES_FIELD_MASK  = 8'h60;
	localparam logic [7:0]  RES_9_BIT       = 8'h00;
	localparam logic [7:0]  RES_10_BIT      = 8'h20;
	localparam logic [7:0]  RES_11_BIT      = 8'h40;
	localparam logic signed [15:0] TEMP_MIN = -16'sd880;
	localparam logic signed [15:0] TEMP_MAX = 16'sd2000;
	localparam logic [7:0]  COUNT_SAT       = 8'hFF;

	typedef logic [SCRATCH_BYTES-1:0][7:0] scratch_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [11:0] temperature;
		logic [2:0]         error_cause;
		logic [7:0]         error_count;
	} out_item_t;

	typedef struct packed {
		logic               in_range;
		logic signed [11:0] temp;
	} decode_t;

	// Reflected CRC-8, one byte, least significant bit first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic [7:0] d;
		c = crc;
		d = b;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/onewire_temp_scratchpad_decoder.sv @@
// ----------------------------------------------------------------------------
// onewire_temp_scratchpad_decoder
// Checks and decodes the nine-byte scratchpad of a 1-Wire temperature sensor.
//
// Feed the scratchpad bytes in order 0 to 8 with action 0; the ninth byte
// produces one result, earlier bytes produce none. A bus reset failure or a
// missing address produces a failure result at once and drops the partial
// frame. The byte CRC, the decode and the error bookkeeping are done between
// the input register and the result register, so a result is in the output
// register when its item leaves the input register. An item can be accepted in
// every cycle; while a result waits under out_stall, the item in the input
// register waits with it and the input is stalled. Failures keep the last good
// reading until the consecutive error count reaches max_errors, then report
// invalid, and report invalid while no good reading exists.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "onewire_temp_scratchpad_decoder_assert.svh"

module onewire_temp_scratchpad_decoder
	import owts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,

	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic [7:0] family_code_q;
	logic [7:0] max_errors_q;

	logic     s1_valid_q;
	in_item_t s1_item_q;

	logic [BYTE_IDX_W-1:0] byte_index_q;
	logic [7:0]            crc_accum_q;
	scratch_t              scratch_q;
	logic [7:0]            fail_count_q;
	logic signed [11:0]    last_good_q;
	logic                  have_good_q;

	logic      out_valid_q;
	out_item_t out_item_q;

	logic                  adv;
	logic                  is_byte;
	logic                  is_fail;
	logic [BYTE_IDX_W-1:0] wr_idx;
	logic [7:0]            crc_next;
	logic                  frame_done;
	logic                  has_result;
	logic                  good;
	logic [7:0]            fc_inc;
	decode_t               dec;
	out_item_t             res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			family_code_q <= FAMILY_RESET;
			max_errors_q  <= MAX_ERRORS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FAMILY_CODE: family_code_q <= cfg_data;
				CFG_MAX_ERRORS:  max_errors_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input register moves on whenever the result register can take
	// whatever it produces.
	assign adv      = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			s1_item_q <= in_item;
		end
	end

	assign is_byte    = s1_item_q.action == ACT_BYTE;
	assign is_fail    = (s1_item_q.action == ACT_BUS) || (s1_item_q.action == ACT_NO_ADDR);
	assign wr_idx     = (byte_index_q >= BYTE_IDX_W'(SCRATCH_BYTES)) ? '0 : byte_index_q;
	assign crc_next   = crc8_byte(crc_accum_q, s1_item_q.data_byte);
	assign frame_done = is_byte && (wr_idx == BYTE_IDX_W'(SCRATCH_BYTES - 1));
	assign has_result = is_fail || frame_done;
	assign good       = frame_done && (crc_next == 8'h00) && dec.in_range;
	assign fc_inc     = (fail_count_q == COUNT_SAT) ? COUNT_SAT : fail_count_q + 8'd1;

	// Bytes 0 to 7 are already stored when the ninth byte arrives.
	owts_decode u_decode (
		.scratch     (scratch_q),
		.family_code (family_code_q),
		.result      (dec)
	);

	always_comb begin
		res.status      = ST_FRESH;
		res.temperature = dec.temp;
		res.error_cause = CAUSE_NONE;
		res.error_count = 8'h00;
		if (!good) begin
			if (s1_item_q.action == ACT_NO_ADDR) begin
				res.error_cause = CAUSE_NO_ADDR;
			end else if (s1_item_q.action == ACT_BUS) begin
				res.error_cause = CAUSE_BUS;
			end else if (crc_next != 8'h00) begin
				res.error_cause = CAUSE_CRC;
			end else begin
				res.error_cause = CAUSE_RANGE;
			end
			res.error_count = fc_inc;
			if ((fc_inc >= max_errors_q) || !have_good_q) begin
				res.status      = ST_INVALID;
				res.temperature = '0;
			end else begin
				res.status      = ST_HELD;
				res.temperature = last_good_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			crc_accum_q  <= 8'h00;
			fail_count_q <= 8'h00;
			last_good_q  <= '0;
			have_good_q  <= 1'b0;
		end else if (adv) begin
			if (is_fail) begin
				byte_index_q <= '0;
				crc_accum_q  <= 8'h00;
			end else if (is_byte) begin
				byte_index_q <= frame_done ? '0 : wr_idx + BYTE_IDX_W'(1);
				crc_accum_q  <= frame_done ? 8'h00 : crc_next;
			end
			if (has_result) begin
				if (good) begin
					fail_count_q <= 8'h00;
					last_good_q  <= dec.temp;
					have_good_q  <= 1'b1;
				end else begin
					fail_count_q <= fc_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_byte) begin
			scratch_q[wr_idx] <= s1_item_q.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_result) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`OWTS_ASSERT_ALWAYS(a_byte_index_bound, byte_index_q < BYTE_IDX_W'(SCRATCH_BYTES), "byte index ran past the scratchpad")
	`OWTS_ASSERT_IMPLY(a_fresh_clean, out_valid_q && (out_item_q.status == ST_FRESH), (out_item_q.error_cause == CAUSE_NONE) && (out_item_q.error_count == 8'h00), "fresh reading carries an error")
	`OWTS_ASSERT_IMPLY(a_invalid_zero, out_valid_q && (out_item_q.status == ST_INVALID), out_item_q.temperature == 12'sd0, "invalid reading has a nonzero temperature")
	`OWTS_ASSERT_IMPLY(a_held_needs_good, out_valid_q && (out_item_q.status == ST_HELD), have_good_q && (out_item_q.error_count != 8'h00), "held value reported without a good reading")

endmodule

@@ hw/rtl/owts_decode.sv @@
// ----------------------------------------------------------------------------
// owts_decode
// Turns the stored scratchpad bytes into a temperature in sixteenths of a
// degree and checks it against the -55 to +125 degree window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owts_decode
	import owts_pkg::*;
(
	input  scratch_t   scratch,
	input  logic [7:0] family_code,
	output decode_t    result
);

	logic [15:0] raw;
	logic [15:0] shifted;
	logic [15:0] value;
	logic [7:0]  res_field;

	assign raw       = {scratch[1], scratch[0]};
	assign shifted   = raw << 3;
	assign res_field = scratch[4] & RES_FIELD_MASK;

	always_comb begin
		if (family_code == NINE_BIT_FAMILY) begin
			// Older part: half-degree reading, refined with count-remain when
			// count-per-degree is sixteen.
			if (scratch[7] == COUNT_PER_C_16) begin
				value = (shifted & FRAC_CLEAR_MASK) + HALF_STEP_BIAS - {8'h00, scratch[6]};
			end else begin
				value = shifted;
			end
		end else begin
			case (res_field)
				RES_9_BIT:  value = {raw[15:3], 3'b000};
				RES_10_BIT: value = {raw[15:2], 2'b00};
				RES_11_BIT: value = {raw[15:1], 1'b0};
				default:    value = raw;
			endcase
		end
	end

	assign result.in_range = ($signed(value) >= TEMP_MIN) && ($signed(value) <= TEMP_MAX);
	assign result.temp     = value[11:0];

endmodule

@@ dv/onewire_readout_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_readout_checker
// Watches the item, result and register channels of the 1-Wire scratchpad
// decoder. It keeps its own copy of the frame, CRC and error bookkeeping. It
// predicts each reading from the accepted bytes and actions, and compares
// every result transfer with the oldest predicted reading, field by field.
// ----------------------------------------------------------------------------

module onewire_readout_checker
	import owts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_item,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_item,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output int unsigned          mismatch_count,
	output int unsigned          outstanding
);

	out_item_t expected_readings [$];
	out_item_t want;

	logic [7:0]            family_code;
	logic [7:0]            error_limit;
	logic [BYTE_IDX_W-1:0] byte_pos;
	logic [7:0]            crc_run;
	scratch_t              pad;
	logic [7:0]            fail_run;
	logic [15:0]           held_raw;
	logic                  have_reading;

	// Reflected CRC-8, data taken least significant bit first.
	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc;
		for (int k = 0; k < 8; k++)
			c = {1'b0, c[7:1]} ^ ((c[0] ^ data[k]) ? CRC_POLY : 8'h00);
		return c;
	endfunction

	task automatic record_failure(input logic [2:0] cause);
		out_item_t r;
		if (fail_run != COUNT_SAT)
			fail_run++;
		r.error_cause = cause;
		r.error_count = fail_run;
		if (fail_run >= error_limit || !have_reading) begin
			r.status      = ST_INVALID;
			r.temperature = '0;
		end else begin
			r.status      = ST_HELD;
			r.temperature = held_raw[11:0];
		end
		expected_readings.insert(expected_readings.size(), r);
	endtask

	task automatic predict_reading(input in_item_t it);
		logic [15:0]        raw;
		logic signed [15:0] t;
		out_item_t          r;
		case (it.action)
			ACT_BYTE: begin
				if (byte_pos >= SCRATCH_BYTES)
					byte_pos = '0;
				pad[byte_pos] = it.data_byte;
				crc_run = crc_step(crc_run, it.data_byte);
				byte_pos++;
				if (byte_pos == SCRATCH_BYTES) begin
					byte_pos = '0;
					if (crc_run != 8'h00) begin
						crc_run = 8'h00;
						record_failure(CAUSE_CRC);
					end else begin
						raw = {pad[1], pad[0]};
						if (family_code == NINE_BIT_FAMILY) begin
							raw = raw << 3;
							// Count-remain refinement only when count-per-degree is 16.
							if (pad[7] == COUNT_PER_C_16)
								raw = (raw & FRAC_CLEAR_MASK) + HALF_STEP_BIAS - {8'h00, pad[6]};
						end else begin
							case (pad[4] & RES_FIELD_MASK)
								RES_9_BIT:  raw[2:0] = 3'b000;
								RES_10_BIT: raw[1:0] = 2'b00;
								RES_11_BIT: raw[0]   = 1'b0;
								default: ;
							endcase
						end
						t = raw;
						if (t < TEMP_MIN || t > TEMP_MAX) begin
							record_failure(CAUSE_RANGE);
						end else begin
							fail_run      = 8'h00;
							held_raw      = raw;
							have_reading  = 1'b1;
							r.status      = ST_FRESH;
							r.temperature = raw[11:0];
							r.error_cause = CAUSE_NONE;
							r.error_count = 8'h00;
							expected_readings.insert(expected_readings.size(), r);
						end
					end
				end
			end
			ACT_BUS: begin
				byte_pos = '0;
				crc_run  = 8'h00;
				record_failure(CAUSE_BUS);
			end
			ACT_NO_ADDR: begin
				byte_pos = '0;
				crc_run  = 8'h00;
				record_failure(CAUSE_NO_ADDR);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			family_code    = FAMILY_RESET;
			error_limit    = MAX_ERRORS_RESET;
			byte_pos       = '0;
			crc_run        = 8'h00;
			pad            = '0;
			fail_run       = 8'h00;
			held_raw       = 16'h0000;
			have_reading   = 1'b0;
			mismatch_count = 0;
			expected_readings.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_FAMILY_CODE)
					family_code = cfg_data;
				else if (cfg_index == CFG_MAX_ERRORS)
					error_limit = cfg_data;
			end

			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result: status %0d temp %0d cause %0d count %0d",
							$realtime, out_item.status, out_item.temperature,
							out_item.error_cause, out_item.error_count);
				end else begin
					want = expected_readings.pop_front();
					if (out_item.status !== want.status ||
							out_item.temperature !== want.temperature ||
							out_item.error_cause !== want.error_cause ||
							out_item.error_count !== want.error_count) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$write("%0t: mismatch: expected status %0d temp %0d cause %0d count %0d",
								$realtime, want.status, want.temperature, want.error_cause,
								want.error_count);
							$display(", got status %0d temp %0d cause %0d count %0d",
								out_item.status, out_item.temperature,
								out_item.error_cause, out_item.error_count);
						end
					end
				end
			end

			if (in_valid && !in_stall)
				predict_reading(in_item);
		end
		outstanding = expected_readings.size();
	end

endmodule

@@ dv/tb_onewire_temp_scratchpad_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_onewire_temp_scratchpad_decoder
// Drives scratchpad frames, failure actions and register writes into the
// decoder under random sender gaps and receiver stalls. Frames carry valid
// CRCs with random contents, with some corrupted, out of range or pure noise.
// The checker beside the block predicts and compares the readings.
// ----------------------------------------------------------------------------

module tb_onewire_temp_scratchpad_decoder;
	import owts_pkg::*;

	localparam logic [1:0] ACT_UNUSED        = 2'd3;
	localparam int         SEGMENTS          = 6;
	localparam int         ITEMS_PER_SEGMENT = 235;
	localparam logic [SEGMENTS-1:0][7:0] SEG_FAMILY =
		{8'd0, 8'd255, NINE_BIT_FAMILY, 8'd0, NINE_BIT_FAMILY, 8'd40};
	localparam logic [SEGMENTS-1:0][7:0] SEG_LIMIT =
		{8'd0, 8'd2, 8'd0, 8'd255, 8'd1, 8'd3};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_item   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data  = '0;

	int unsigned mismatch_count;
	int unsigned outstanding;
	int unsigned tx_idle_pct  = 38;
	int unsigned rx_stall_pct = 73;
	int unsigned items_sent   = 0;
	logic [7:0]  cur_family   = FAMILY_RESET;

	onewire_temp_scratchpad_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	onewire_readout_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_item       (out_item),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// All tasks below start and end at a falling edge.
	task automatic push_item(input logic [1:0] act, input logic [7:0] data);
		in_item_t it;
		it.action    = act;
		it.data_byte = data;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (act != ACT_UNUSED)
			items_sent++;
	endtask

	task automatic push_failure();
		push_item($urandom_range(1) ? ACT_BUS : ACT_NO_ADDR, 8'($urandom));
	endtask

	// Sends a frame with the given raw reading and resolution byte and a
	// matching CRC, optionally with one bit flipped somewhere in the frame.
	task automatic send_reading(input logic [15:0] raw, input logic [7:0] res_cfg,
			input logic corrupt);
		logic [7:0] pad [SCRATCH_BYTES];
		logic [7:0] crc;
		for (int i = 0; i < SCRATCH_BYTES; i++)
			pad[i] = 8'($urandom);
		pad[0] = raw[7:0];
		pad[1] = raw[15:8];
		pad[4] = res_cfg;
		pad[6] = ($urandom_range(3) != 0) ? 8'($urandom_range(16)) : 8'($urandom);
		pad[7] = ($urandom_range(3) != 0) ? COUNT_PER_C_16 : 8'($urandom);
		crc = 8'h00;
		for (int i = 0; i < SCRATCH_BYTES - 1; i++)
			crc = crc8_byte(crc, pad[i]);
		pad[SCRATCH_BYTES-1] = crc;
		if (corrupt)
			pad[$urandom_range(SCRATCH_BYTES-1)] ^= 8'h01 << $urandom_range(7);
		for (int i = 0; i < SCRATCH_BYTES; i++)
			push_item(ACT_BYTE, pad[i]);
	endtask

	function automatic logic [15:0] pick_temp();
		if (cur_family == NINE_BIT_FAMILY)
			return 16'($urandom_range(360)) - 16'd110;
		return 16'($urandom_range(2880)) - 16'd880;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		// Partial frames give no result but may still be in the pipeline.
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_step();
		int unsigned r;
		int unsigned n;
		r = $urandom_range(99);
		if (r < 45) begin
			send_reading(pick_temp(), 8'($urandom), 1'b0);
		end else if (r < 53) begin
			send_reading(16'($urandom), 8'($urandom), 1'b0);
		end else if (r < 61) begin
			send_reading(pick_temp(), 8'($urandom), 1'b1);
		end else if (r < 66) begin
			for (int i = 0; i < SCRATCH_BYTES; i++)
				push_item(ACT_BYTE, 8'($urandom));
		end else if (r < 80) begin
			push_failure();
		end else if (r < 88) begin
			n = $urandom_range(SCRATCH_BYTES - 1, 1);
			repeat (n) push_item(ACT_BYTE, 8'($urandom));
			push_failure();
		end else if (r < 95) begin
			push_item(ACT_UNUSED, 8'($urandom));
		end else begin
			n = $urandom_range(8, 2);
			repeat (n) push_failure();
		end
		if ($urandom_range(99) == 0)
			drain();
	endtask

	initial begin
		int unsigned seg_start;
		logic [7:0]  fam;
		logic [7:0]  lim;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Failures before any good reading report invalid; the unused action is dropped.
		push_item(ACT_BUS, 8'h00);
		push_item(ACT_NO_ADDR, 8'hFF);
		push_item(ACT_UNUSED, 8'hA5);
		send_reading(TEMP_MAX, RES_FIELD_MASK, 1'b0);
		// A failure in the middle of a frame drops the partial frame.
		repeat (3) push_item(ACT_BYTE, 8'($urandom));
		push_item(ACT_NO_ADDR, 8'h00);
		send_reading(TEMP_MIN, RES_FIELD_MASK, 1'b0);

		for (int s = 0; s < SEGMENTS; s++) begin
			drain();
			if (s == 2) begin
				tx_idle_pct  = 73;
				rx_stall_pct = 38;
			end else if (s == 4) begin
				tx_idle_pct  = 0;
				rx_stall_pct = 0;
			end
			fam = SEG_FAMILY[s];
			lim = SEG_LIMIT[s];
			if (s == SEGMENTS - 1) begin
				fam = 8'($urandom);
				lim = 8'($urandom);
			end
			write_reg(CFG_FAMILY_CODE, fam);
			write_reg(CFG_MAX_ERRORS, lim);
			cfg_valid  <= 1'b0;
			cur_family = fam;

			seg_start = items_sent;
			// With the widest error limit, run the count into saturation.
			if (lim == 8'd255) begin
				send_reading(pick_temp(), 8'($urandom), 1'b0);
				repeat (270) push_failure();
			end
			while (items_sent - seg_start < ITEMS_PER_SEGMENT)
				random_step();
		end

		drain();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/owts_pkg.sv
hw/rtl/owts_decode.sv
hw/rtl/onewire_temp_scratchpad_decoder.sv
dv/onewire_readout_checker.sv
dv/tb_onewire_temp_scratchpad_decoder.sv
